/* design/assert_macros.svh */
// Assertion helpers for the design files; only the top-level tokenizer includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rstok_pkg.sv */
`timescale 1ns / 1ps

package rstok_pkg;

  localparam int KIND_W     = 6;
  localparam int FLEN_W     = 12;
  localparam int FLEN_MAX   = 4095;
  localparam int RES_MAX    = 3;
  localparam int QDEPTH     = 4;

  typedef enum logic [KIND_W-1:0] {
    K_UNDEF    = 6'd0,
    K_END      = 6'd1,
    K_ERROR    = 6'd2,
    K_STR      = 6'd3,
    K_NUM      = 6'd4,
    K_SYMBOL   = 6'd5,
    K_LASSIGN  = 6'd6,
    K_NEWLINE  = 6'd7,
    K_EQASSIGN = 6'd10,
    K_RASSIGN  = 6'd11,
    K_LBB      = 6'd12,
    K_GT       = 6'd21,
    K_GE       = 6'd22,
    K_LT       = 6'd23,
    K_LE       = 6'd24,
    K_EQ       = 6'd25,
    K_NE       = 6'd26,
    K_AND      = 6'd27,
    K_OR       = 6'd28,
    K_AND2     = 6'd29,
    K_OR2      = 6'd30,
    K_NSGET    = 6'd31,
    K_NSGETINT = 6'd32,
    K_PLUS     = 6'd33,
    K_MINUS    = 6'd34,
    K_STAR     = 6'd35,
    K_DIVIDE   = 6'd36,
    K_SPECIAL  = 6'd38,
    K_COLON    = 6'd39,
    K_NOT      = 6'd40,
    K_LBRACE   = 6'd41,
    K_RBRACE   = 6'd42,
    K_LPAREN   = 6'd43,
    K_RPAREN   = 6'd44,
    K_LBRACKET = 6'd45,
    K_RBRACKET = 6'd46,
    K_STAR2    = 6'd47,
    K_CARET    = 6'd48,
    K_TILDE    = 6'd49,
    K_DOLLAR   = 6'd50,
    K_AT       = 6'd51
  } tok_kind_t;

  typedef enum logic [4:0] {
    M_IDLE, M_COMMENT, M_SYMBOL, M_DOT, M_NUM, M_EXPMARK, M_EXPSIGN, M_EXPDIG,
    M_STRING, M_STRESC, M_SPECIAL, M_LT, M_LTLT, M_MINUS, M_MINUSGT, M_COLON,
    M_COLON2, M_GT, M_BANG, M_EQ, M_AMP, M_BAR, M_LBRACK, M_STAR
  } scan_mode_t;

  typedef struct packed {
    tok_kind_t         kind;
    logic [FLEN_W-1:0] len;
  } tok_res_t;

  // All results caused by one input character.
  typedef struct packed {
    logic [1:0]           cnt;
    tok_res_t [RES_MAX-1:0] res;
  } step_rec_t;

  typedef struct packed {
    logic push;
    logic idle;
  } scan_stat_t;

endpackage

/* design/rstok_scan.sv */
`timescale 1ns / 1ps

module rstok_scan #(
  parameter int LENGTH_MAX = 4095
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic [7:0]            char_code,
  input  logic                  end_of_text,
  output rstok_pkg::step_rec_t  rec,
  output rstok_pkg::scan_stat_t stat
);
  import rstok_pkg::*;

  localparam int LEN_W = $clog2(LENGTH_MAX + 1);
  localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(LENGTH_MAX);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_BQ    = 8'h60;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef struct packed {
    logic       g;
    logic       cf;
    tok_kind_t  ck;
    logic       rs;
    logic       ds;
    logic       clr;
    scan_mode_t nm;
  } act_t;

  scan_mode_t        mode_r, mode_nxt;
  logic [7:0]        quote_r, quote_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              dot_r, dot_nxt;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_tail(input logic [7:0] c);
    return is_alpha(c) || is_dec(c) || (c == ".") || (c == "_");
  endfunction

  function automatic logic valid_esc(input logic [7:0] c);
    return (c == "0") || (c == "a") || (c == "b") || (c == "f") || (c == "n") ||
           (c == "r") || (c == "t") || (c == "v") || (c == CH_BSL) || (c == CH_DQ) ||
           (c == CH_SQ) || (c == CH_BQ) || (c == " ") || (c == CH_NL);
  endfunction

  function automatic logic [LEN_W-1:0] grow(input logic [LEN_W-1:0] l);
    return (l < LEN_SAT) ? l + 1'b1 : LEN_SAT;
  endfunction

  function automatic logic [FLEN_W-1:0] clamp(input logic [LEN_W-1:0] l);
    logic [31:0] w;
    w = 32'(l);
    return (w > 32'(FLEN_MAX)) ? FLEN_W'(FLEN_MAX) : w[FLEN_W-1:0];
  endfunction

  function automatic act_t pair_act(input logic [7:0] c, input logic [7:0] second,
                                    input tok_kind_t lk, input tok_kind_t sk,
                                    input scan_mode_t m);
    act_t a;
    a    = '0;
    a.nm = m;
    a.cf = 1'b1;
    if (c == second) begin
      a.g  = 1'b1;
      a.ck = lk;
    end else begin
      a.ck = sk;
      a.rs = 1'b1;
    end
    return a;
  endfunction

  always_comb begin
    scan_mode_t       m;
    logic [7:0]       q;
    logic [LEN_W-1:0] l;
    logic             d;
    logic [7:0]       c;
    act_t             a;
    logic             do_start;
    logic [3:0]       sl_v;
    tok_kind_t        sl_k [4];
    logic [LEN_W-1:0] sl_l [4];
    logic [2:0]       n;

    c    = char_code;
    m    = mode_r;
    q    = quote_r;
    l    = len_r;
    d    = dot_r;
    a    = '0;
    a.nm = mode_r;
    a.ck = K_UNDEF;
    sl_v = '0;
    for (int i = 0; i < 4; i++) begin
      sl_k[i] = K_UNDEF;
      sl_l[i] = '0;
    end

    // Extend the open token.
    case (mode_r)
      M_IDLE: ;
      M_COMMENT: begin
        if (c == CH_NL) begin
          a.clr = 1'b1;
          a.rs  = 1'b1;
        end
      end
      M_SYMBOL: begin
        if (is_tail(c)) a.g = 1'b1;
        else begin a.cf = 1'b1; a.ck = K_SYMBOL; a.rs = 1'b1; end
      end
      M_DOT: begin
        if (is_dec(c)) begin
          a.g = 1'b1; a.ds = 1'b1; a.nm = M_NUM;
        end else if (is_tail(c)) begin
          a.g = 1'b1; a.nm = M_SYMBOL;
        end else begin
          a.cf = 1'b1; a.ck = K_SYMBOL; a.rs = 1'b1;
        end
      end
      M_NUM: begin
        if (is_dec(c)) a.g = 1'b1;
        else if ((c == ".") && !dot_r) begin a.g = 1'b1; a.ds = 1'b1; end
        else if ((c == "e") || (c == "E")) begin a.g = 1'b1; a.nm = M_EXPMARK; end
        else if (c == "L") begin a.g = 1'b1; a.cf = 1'b1; a.ck = K_NUM; end
        else begin a.cf = 1'b1; a.ck = K_NUM; a.rs = 1'b1; end
      end
      M_EXPMARK: begin
        if (is_dec(c)) begin a.g = 1'b1; a.nm = M_EXPDIG; end
        else if ((c == "+") || (c == "-")) begin a.g = 1'b1; a.nm = M_EXPSIGN; end
        else begin a.cf = 1'b1; a.ck = K_ERROR; a.rs = 1'b1; end
      end
      M_EXPSIGN: begin
        if (is_dec(c)) begin a.g = 1'b1; a.nm = M_EXPDIG; end
        else begin a.cf = 1'b1; a.ck = K_ERROR; a.rs = 1'b1; end
      end
      M_EXPDIG: begin
        if (is_dec(c)) a.g = 1'b1;
        else if (c == "L") begin a.g = 1'b1; a.cf = 1'b1; a.ck = K_NUM; end
        else begin a.cf = 1'b1; a.ck = K_NUM; a.rs = 1'b1; end
      end
      M_STRING: begin
        a.g = 1'b1;
        if (c == CH_BSL) a.nm = M_STRESC;
        else if (c == quote_r) begin
          a.cf = 1'b1;
          a.ck = dot_r ? K_ERROR : K_STR;
        end
      end
      M_STRESC: begin
        a.g  = 1'b1;
        a.ds = !valid_esc(c);
        a.nm = M_STRING;
      end
      M_SPECIAL: begin
        a.g = 1'b1;
        if (c == "%") begin a.cf = 1'b1; a.ck = K_SPECIAL; end
      end
      M_LT: begin
        if (c == "=") begin a.g = 1'b1; a.cf = 1'b1; a.ck = K_LE; end
        else if (c == "-") begin a.g = 1'b1; a.cf = 1'b1; a.ck = K_LASSIGN; end
        else if (c == "<") begin a.g = 1'b1; a.nm = M_LTLT; end
        else begin a.cf = 1'b1; a.ck = K_LT; a.rs = 1'b1; end
      end
      M_LTLT:    a = pair_act(c, "-", K_LASSIGN, K_ERROR, mode_r);
      M_MINUS: begin
        if (c == ">") begin a.g = 1'b1; a.nm = M_MINUSGT; end
        else begin a.cf = 1'b1; a.ck = K_MINUS; a.rs = 1'b1; end
      end
      M_MINUSGT: a = pair_act(c, ">", K_RASSIGN, K_RASSIGN, mode_r);
      M_COLON: begin
        if (c == ":") begin a.g = 1'b1; a.nm = M_COLON2; end
        else a = pair_act(c, "=", K_LASSIGN, K_COLON, mode_r);
      end
      M_COLON2:  a = pair_act(c, ":", K_NSGETINT, K_NSGET, mode_r);
      M_GT:      a = pair_act(c, "=", K_GE, K_GT, mode_r);
      M_BANG:    a = pair_act(c, "=", K_NE, K_NOT, mode_r);
      M_EQ:      a = pair_act(c, "=", K_EQ, K_EQASSIGN, mode_r);
      M_AMP:     a = pair_act(c, "&", K_AND2, K_AND, mode_r);
      M_BAR:     a = pair_act(c, "|", K_OR2, K_OR, mode_r);
      M_LBRACK:  a = pair_act(c, "[", K_LBB, K_LBRACKET, mode_r);
      M_STAR:    a = pair_act(c, "*", K_STAR2, K_STAR, mode_r);
      default: begin
        a.clr = 1'b1;
        a.rs  = 1'b1;
      end
    endcase

    if (a.g) l = grow(l);
    if (a.ds) d = 1'b1;
    m = a.nm;
    if (a.cf) begin
      sl_v[0] = 1'b1;
      sl_k[0] = a.ck;
      sl_l[0] = l;
    end
    if (a.cf || a.clr) begin
      m = M_IDLE; q = '0; l = '0; d = 1'b0;
    end

    // Start a new token on this character.
    do_start = (mode_r == M_IDLE) || a.rs;
    if (do_start) begin
      m = M_IDLE;
      q = '0;
      l = LEN_W'(1);
      d = 1'b0;
      case (c)
        " ", CH_TAB, CH_FF: l = '0;
        CH_NL: begin sl_v[1] = 1'b1; sl_k[1] = K_NEWLINE; end
        "#": begin l = '0; m = M_COMMENT; end
        CH_SQ, CH_DQ, CH_BQ: begin q = c; m = M_STRING; end
        "%": m = M_SPECIAL;
        ".": m = M_DOT;
        "<": m = M_LT;
        "-": m = M_MINUS;
        ":": m = M_COLON;
        ">": m = M_GT;
        "!": m = M_BANG;
        "=": m = M_EQ;
        "&": m = M_AMP;
        "|": m = M_BAR;
        "[": m = M_LBRACK;
        "*": m = M_STAR;
        "{": begin sl_v[1] = 1'b1; sl_k[1] = K_LBRACE; end
        "}": begin sl_v[1] = 1'b1; sl_k[1] = K_RBRACE; end
        "(": begin sl_v[1] = 1'b1; sl_k[1] = K_LPAREN; end
        ")": begin sl_v[1] = 1'b1; sl_k[1] = K_RPAREN; end
        "]": begin sl_v[1] = 1'b1; sl_k[1] = K_RBRACKET; end
        "+": begin sl_v[1] = 1'b1; sl_k[1] = K_PLUS; end
        "/": begin sl_v[1] = 1'b1; sl_k[1] = K_DIVIDE; end
        "^": begin sl_v[1] = 1'b1; sl_k[1] = K_CARET; end
        "~": begin sl_v[1] = 1'b1; sl_k[1] = K_TILDE; end
        "$": begin sl_v[1] = 1'b1; sl_k[1] = K_DOLLAR; end
        "@": begin sl_v[1] = 1'b1; sl_k[1] = K_AT; end
        default: begin
          if (is_dec(c)) m = M_NUM;
          else if (is_alpha(c)) m = M_SYMBOL;
          else begin sl_v[1] = 1'b1; sl_k[1] = K_ERROR; end
        end
      endcase
      sl_l[1] = l;
      if (sl_v[1]) begin
        m = M_IDLE; q = '0; l = '0; d = 1'b0;
      end
    end

    // Flush at end of text.
    if (end_of_text) begin
      sl_v[2] = 1'b1;
      sl_l[2] = l;
      case (m)
        M_SYMBOL, M_DOT: sl_k[2] = K_SYMBOL;
        M_NUM, M_EXPDIG: sl_k[2] = K_NUM;
        M_EXPMARK, M_EXPSIGN, M_STRING, M_STRESC, M_SPECIAL, M_LTLT: sl_k[2] = K_ERROR;
        M_LT:      sl_k[2] = K_LT;
        M_MINUS:   sl_k[2] = K_MINUS;
        M_MINUSGT: sl_k[2] = K_RASSIGN;
        M_COLON:   sl_k[2] = K_COLON;
        M_COLON2:  sl_k[2] = K_NSGET;
        M_GT:      sl_k[2] = K_GT;
        M_BANG:    sl_k[2] = K_NOT;
        M_EQ:      sl_k[2] = K_EQASSIGN;
        M_AMP:     sl_k[2] = K_AND;
        M_BAR:     sl_k[2] = K_OR;
        M_LBRACK:  sl_k[2] = K_LBRACKET;
        M_STAR:    sl_k[2] = K_STAR;
        default:   sl_v[2] = 1'b0;
      endcase
      sl_v[3] = 1'b1;
      sl_k[3] = K_END;
      m = M_IDLE; q = '0; l = '0; d = 1'b0;
    end

    // Pack the results in order.
    rec = '0;
    n   = '0;
    for (int i = 0; i < 4; i++) begin
      if (sl_v[i] && (n < 3'(RES_MAX))) begin
        rec.res[n[1:0]].kind = sl_k[i];
        rec.res[n[1:0]].len  = clamp(sl_l[i]);
        n = n + 3'd1;
      end
    end
    rec.cnt = n[1:0];

    mode_nxt  = m;
    quote_nxt = q;
    len_nxt   = l;
    dot_nxt   = d;
  end

  assign stat.push = (rec.cnt != 2'd0);
  assign stat.idle = (mode_r == M_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      quote_r <= '0;
      len_r   <= '0;
      dot_r   <= 1'b0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      len_r   <= len_nxt;
      dot_r   <= dot_nxt;
    end
  end

endmodule

/* design/rstok_fifo.sv */
`timescale 1ns / 1ps

module rstok_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rstok_pkg::step_rec_t wr_data,
  input  logic                 pop,
  output rstok_pkg::step_rec_t rd_data,
  output logic                 full,
  output logic                 empty
);
  import rstok_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  step_rec_t       mem_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (pop)  rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* design/rstok_emit.sv */
`timescale 1ns / 1ps

module rstok_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rstok_pkg::step_rec_t head,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output rstok_pkg::tok_res_t  res,
  output logic                 res_last
);
  import rstok_pkg::*;

  step_rec_t  cur_r, cur_nxt;
  logic       cur_v_r, cur_v_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       fire;

  assign res_valid = cur_v_r;
  assign res       = cur_r.res[idx_r];
  assign res_last  = ((idx_r + 2'd1) == cur_r.cnt);
  assign fire      = cur_v_r && res_ready;
  assign pop       = !q_empty && (!cur_v_r || (fire && res_last));

  always_comb begin
    cur_nxt   = cur_r;
    cur_v_nxt = cur_v_r;
    idx_nxt   = idx_r;
    if (pop) begin
      cur_nxt   = head;
      cur_v_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (fire) begin
      if (res_last) cur_v_nxt = 1'b0;
      else idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      cur_v_r <= cur_v_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

/* design/r_source_tokenizer.sv */
`timescale 1ns / 1ps

// Streaming lexer for R source text. One character is taken per beat on the input
// stream, with in_tlast on the final character of a source; the output stream gives
// one token per beat (kind on out_tuser, length on out_tdata), with out_tlast on the
// last token caused by an input character. A character can cause up to three tokens
// and causes none while a token is still growing; a token that can only end on the
// following character comes out with that character. The scanner takes a character
// every cycle as long as its four-entry result queue has room, so the input runs at
// one character per cycle while the output side keeps up, and the output gives one
// token per cycle while out_tready is high. Lengths count to LENGTH_MAX, max 4095.
module r_source_tokenizer #(
  parameter int LENGTH_MAX = 4095
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] token_length, zero above
  output logic [5:0]  out_tuser,  // [5:0] token_kind
  output logic        out_tlast   // run_end
);
  import rstok_pkg::*;
`include "assert_macros.svh"

  logic       in_fire;
  step_rec_t  scan_rec;
  scan_stat_t scan_stat;
  step_rec_t  q_head;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  tok_res_t   emit_res;
  logic       end_beat;
  logic       end_ok;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  rstok_scan #(
    .LENGTH_MAX(LENGTH_MAX)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .char_code   (in_tdata),
    .end_of_text (in_tlast),
    .rec         (scan_rec),
    .stat        (scan_stat)
  );

  rstok_fifo #(
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_fire && scan_stat.push),
    .wr_data (scan_rec),
    .pop     (q_pop),
    .rd_data (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  rstok_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (emit_res),
    .res_last  (out_tlast)
  );

  assign out_tdata = {4'b0, emit_res.len};
  assign out_tuser = emit_res.kind;

  assign end_beat = out_tvalid && (out_tuser == K_END);
  assign end_ok   = out_tlast && (out_tdata == 16'd0);

  `ASSERT_NOW(a_eot_results, clk, rst_n, in_fire && in_tlast, scan_stat.push, "no end beat")
  `ASSERT_NEXT(a_eot_idle, clk, rst_n, in_fire && in_tlast, scan_stat.idle, "scan not idle")
  `ASSERT_NOW(a_end_last, clk, rst_n, end_beat, end_ok, "end token not last or nonzero length")

endmodule

/* bench/tb_r_source_tokenizer.sv */
`timescale 1ns / 1ps

module tb_r_source_tokenizer;
  import rstok_pkg::*;

  localparam int SAT_LEN = 4095;
  localparam int CYC_LIMIT = 400000;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_DQ = 8'h22;
  localparam logic [7:0] CH_SQ = 8'h27;
  localparam logic [7:0] CH_BS = 8'h5C;
  localparam logic [7:0] CH_BQ = 8'h60;

  typedef struct {
    tok_kind_t   kind;
    logic [11:0] len;
    logic        last;
  } tok_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [5:0]  out_tuser;
  logic        out_tlast;

  tok_exp_t   tok_exp_q[$];
  logic [7:0] src_q[$];
  int         mism_count = 0;
  int         cyc_count = 0;
  int         sent_chars = 0;
  int         burst_left = 0;
  int         gap_max = 0;
  int         rdy_tick = 0;
  int         rdy_style = 0;

  scan_mode_t  lx_mode;
  logic [7:0]  lx_quote;
  int          lx_len;
  bit          lx_dot;
  tok_kind_t   st_kind[RES_MAX];
  int          st_len[RES_MAX];
  int          st_n;

  string op_text[$] = '{"<-", "<<-", "<<", "<=", "<", "->", "->>", ":=", "-=", "::",
                        ":::", ":", ">=", ">", "!=", "!", "==", "=", "&&", "&", "||",
                        "|", "[[", "[", "**", "*", "+", "/", "^", "~", "$", "@", "{",
                        "}", "(", ")", "]", "-"};

  r_source_tokenizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_dec(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_sym_tail(logic [7:0] c);
    return is_alpha(c) || is_dec(c) || c == "." || c == "_";
  endfunction

  function automatic void tok_put(tok_kind_t k, int n);
    if (st_n < RES_MAX) begin
      st_kind[st_n] = k;
      st_len[st_n] = (n > FLEN_MAX) ? FLEN_MAX : n;
      st_n++;
    end
  endfunction

  function automatic void lex_clear();
    lx_mode = M_IDLE;
    lx_quote = 8'h00;
    lx_len = 0;
    lx_dot = 1'b0;
  endfunction

  function automatic void lex_grow();
    if (lx_len < SAT_LEN) lx_len++;
  endfunction

  function automatic void lex_close(tok_kind_t k);
    tok_put(k, lx_len);
    lex_clear();
  endfunction

  // Returns 1 when the character did not belong to the operator and must start a new token.
  function automatic bit lex_pair(logic [7:0] c, logic [7:0] second, tok_kind_t long_k,
                                  tok_kind_t short_k);
    if (c == second) begin
      lex_grow();
      lex_close(long_k);
      return 1'b0;
    end
    lex_close(short_k);
    return 1'b1;
  endfunction

  function automatic void lex_begin(logic [7:0] c);
    lex_clear();
    lx_len = 1;
    case (c)
      " ", CH_TAB, CH_FF: lx_len = 0;
      CH_NL: lex_close(K_NEWLINE);
      "#": begin
        lx_len = 0;
        lx_mode = M_COMMENT;
      end
      CH_SQ, CH_DQ, CH_BQ: begin
        lx_quote = c;
        lx_mode = M_STRING;
      end
      "%": lx_mode = M_SPECIAL;
      ".": lx_mode = M_DOT;
      "<": lx_mode = M_LT;
      "-": lx_mode = M_MINUS;
      ":": lx_mode = M_COLON;
      ">": lx_mode = M_GT;
      "!": lx_mode = M_BANG;
      "=": lx_mode = M_EQ;
      "&": lx_mode = M_AMP;
      "|": lx_mode = M_BAR;
      "[": lx_mode = M_LBRACK;
      "*": lx_mode = M_STAR;
      "{": lex_close(K_LBRACE);
      "}": lex_close(K_RBRACE);
      "(": lex_close(K_LPAREN);
      ")": lex_close(K_RPAREN);
      "]": lex_close(K_RBRACKET);
      "+": lex_close(K_PLUS);
      "/": lex_close(K_DIVIDE);
      "^": lex_close(K_CARET);
      "~": lex_close(K_TILDE);
      "$": lex_close(K_DOLLAR);
      "@": lex_close(K_AT);
      default: begin
        if (is_dec(c)) lx_mode = M_NUM;
        else if (is_alpha(c)) lx_mode = M_SYMBOL;
        else lex_close(K_ERROR);
      end
    endcase
  endfunction

  function automatic bit lex_extend(logic [7:0] c);
    case (lx_mode)
      M_COMMENT: begin
        if (c == CH_NL) begin
          lex_clear();
          return 1'b1;
        end
        return 1'b0;
      end
      M_SYMBOL: begin
        if (is_sym_tail(c)) begin
          lex_grow();
          return 1'b0;
        end
        lex_close(K_SYMBOL);
        return 1'b1;
      end
      M_DOT: begin
        if (is_dec(c)) begin
          lex_grow();
          lx_dot = 1'b1;
          lx_mode = M_NUM;
          return 1'b0;
        end
        if (is_sym_tail(c)) begin
          lex_grow();
          lx_mode = M_SYMBOL;
          return 1'b0;
        end
        lex_close(K_SYMBOL);
        return 1'b1;
      end
      M_NUM: begin
        if (is_dec(c)) begin
          lex_grow();
          return 1'b0;
        end
        if (c == "." && !lx_dot) begin
          lex_grow();
          lx_dot = 1'b1;
          return 1'b0;
        end
        if (c == "e" || c == "E") begin
          lex_grow();
          lx_mode = M_EXPMARK;
          return 1'b0;
        end
        if (c == "L") begin
          lex_grow();
          lex_close(K_NUM);
          return 1'b0;
        end
        lex_close(K_NUM);
        return 1'b1;
      end
      M_EXPMARK: begin
        if (is_dec(c)) begin
          lex_grow();
          lx_mode = M_EXPDIG;
          return 1'b0;
        end
        if (c == "+" || c == "-") begin
          lex_grow();
          lx_mode = M_EXPSIGN;
          return 1'b0;
        end
        lex_close(K_ERROR);
        return 1'b1;
      end
      M_EXPSIGN: begin
        if (is_dec(c)) begin
          lex_grow();
          lx_mode = M_EXPDIG;
          return 1'b0;
        end
        lex_close(K_ERROR);
        return 1'b1;
      end
      M_EXPDIG: begin
        if (is_dec(c)) begin
          lex_grow();
          return 1'b0;
        end
        if (c == "L") begin
          lex_grow();
          lex_close(K_NUM);
          return 1'b0;
        end
        lex_close(K_NUM);
        return 1'b1;
      end
      M_STRING: begin
        lex_grow();
        if (c == CH_BS) lx_mode = M_STRESC;
        else if (c == lx_quote) lex_close(lx_dot ? K_ERROR : K_STR);
        return 1'b0;
      end
      M_STRESC: begin
        lex_grow();
        case (c)
          "0", "a", "b", "f", "n", "r", "t", "v", CH_BS, CH_DQ, CH_SQ, CH_BQ, " ", CH_NL: ;
          default: lx_dot = 1'b1;
        endcase
        lx_mode = M_STRING;
        return 1'b0;
      end
      M_SPECIAL: begin
        lex_grow();
        if (c == "%") lex_close(K_SPECIAL);
        return 1'b0;
      end
      M_LT: begin
        if (c == "=") begin
          lex_grow();
          lex_close(K_LE);
          return 1'b0;
        end
        if (c == "-") begin
          lex_grow();
          lex_close(K_LASSIGN);
          return 1'b0;
        end
        if (c == "<") begin
          lex_grow();
          lx_mode = M_LTLT;
          return 1'b0;
        end
        lex_close(K_LT);
        return 1'b1;
      end
      M_LTLT: return lex_pair(c, "-", K_LASSIGN, K_ERROR);
      M_MINUS: begin
        if (c == ">") begin
          lex_grow();
          lx_mode = M_MINUSGT;
          return 1'b0;
        end
        lex_close(K_MINUS);
        return 1'b1;
      end
      M_MINUSGT: return lex_pair(c, ">", K_RASSIGN, K_RASSIGN);
      M_COLON: begin
        if (c == ":") begin
          lex_grow();
          lx_mode = M_COLON2;
          return 1'b0;
        end
        return lex_pair(c, "=", K_LASSIGN, K_COLON);
      end
      M_COLON2: return lex_pair(c, ":", K_NSGETINT, K_NSGET);
      M_GT: return lex_pair(c, "=", K_GE, K_GT);
      M_BANG: return lex_pair(c, "=", K_NE, K_NOT);
      M_EQ: return lex_pair(c, "=", K_EQ, K_EQASSIGN);
      M_AMP: return lex_pair(c, "&", K_AND2, K_AND);
      M_BAR: return lex_pair(c, "|", K_OR2, K_OR);
      M_LBRACK: return lex_pair(c, "[", K_LBB, K_LBRACKET);
      M_STAR: return lex_pair(c, "*", K_STAR2, K_STAR);
      default: begin
        lex_clear();
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void lex_flush();
    case (lx_mode)
      M_SYMBOL, M_DOT: lex_close(K_SYMBOL);
      M_NUM, M_EXPDIG: lex_close(K_NUM);
      M_EXPMARK, M_EXPSIGN, M_STRING, M_STRESC, M_SPECIAL, M_LTLT: lex_close(K_ERROR);
      M_LT: lex_close(K_LT);
      M_MINUS: lex_close(K_MINUS);
      M_MINUSGT: lex_close(K_RASSIGN);
      M_COLON: lex_close(K_COLON);
      M_COLON2: lex_close(K_NSGET);
      M_GT: lex_close(K_GT);
      M_BANG: lex_close(K_NOT);
      M_EQ: lex_close(K_EQASSIGN);
      M_AMP: lex_close(K_AND);
      M_BAR: lex_close(K_OR);
      M_LBRACK: lex_close(K_LBRACKET);
      M_STAR: lex_close(K_STAR);
      default: ;
    endcase
    lex_clear();
    tok_put(K_END, 0);
  endfunction

  function automatic void lex_step(logic [7:0] c, logic eot);
    tok_exp_t t;
    st_n = 0;
    if (lx_mode == M_IDLE) lex_begin(c);
    else if (lex_extend(c)) lex_begin(c);
    if (eot) lex_flush();
    for (int i = 0; i < st_n; i++) begin
      t.kind = st_kind[i];
      t.len = st_len[i][11:0];
      t.last = (i == st_n - 1);
      tok_exp_q.insert(tok_exp_q.size(), t);
    end
  endfunction

  always @(posedge clk) begin
    tok_exp_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) lex_step(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (tok_exp_q.size() == 0) begin
          mism_count++;
          if (mism_count <= 10)
            $display("extra token: kind %0d len %0d last %0b", out_tuser,
                     out_tdata[11:0], out_tlast);
        end else begin
          want = tok_exp_q.pop_front();
          if (out_tuser !== want.kind || out_tdata[11:0] !== want.len ||
              out_tdata[15:12] !== 4'd0 || out_tlast !== want.last) begin
            mism_count++;
            if (mism_count <= 10)
              $display("token mismatch: expected kind %0d len %0d last %0b, got %0d %h %0b",
                       want.kind, want.len, want.last, out_tuser, out_tdata, out_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    rdy_tick <= rdy_tick + 1;
    if (rdy_tick % 97 == 0) rdy_style <= $urandom_range(0, 3);
    case (rdy_style)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (rdy_tick % 3 == 0);
      default: out_tready <= (rdy_tick % 16) < 5;
    endcase
  end

  always @(posedge clk) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count == CYC_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_char(logic [7:0] c, logic eot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    sent_chars++;
  endtask

  task automatic send_source(bit with_eot);
    for (int i = 0; i < src_q.size(); i++)
      send_char(src_q[i], with_eot && (i == src_q.size() - 1));
    src_q.delete();
  endtask

  task automatic wait_for_tokens();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tok_exp_q.size() != 0) @(posedge clk);
  endtask

  function automatic void src_add(logic [7:0] ch);
    src_q.insert(src_q.size(), ch);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) src_add(s[i]);
  endfunction

  function automatic logic [7:0] rand_alpha();
    logic [7:0] a;
    a = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? "a" + a : "A" + a;
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic void add_random_lexeme();
    logic [7:0] q;
    logic [7:0] ch;
    case ($urandom_range(0, 17))
      0, 1, 2: begin
        src_add(rand_alpha());
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 3))
            0: src_add(rand_alpha());
            1: src_add(rand_digit());
            2: src_add(".");
            default: src_add("_");
          endcase
        end
      end
      3, 4, 5: begin
        repeat ($urandom_range(1, 4)) src_add(rand_digit());
        if ($urandom_range(0, 1)) begin
          src_add(".");
          repeat ($urandom_range(0, 3)) src_add(rand_digit());
        end
        if ($urandom_range(0, 2) == 0) begin
          src_add($urandom_range(0, 1) ? "e" : "E");
          case ($urandom_range(0, 2))
            0: src_add("+");
            1: src_add("-");
            default: ;
          endcase
          repeat ($urandom_range(0, 2)) src_add(rand_digit());
        end
        if ($urandom_range(0, 4) == 0) src_add("L");
      end
      6: begin
        src_add(".");
        case ($urandom_range(0, 3))
          0: src_add(rand_digit());
          1: src_add(rand_alpha());
          2: src_add(".");
          default: ;
        endcase
      end
      7, 8: begin
        case ($urandom_range(0, 2))
          0: q = CH_SQ;
          1: q = CH_DQ;
          default: q = CH_BQ;
        endcase
        src_add(q);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0) begin
            src_add(CH_BS);
            case ($urandom_range(0, 17))
              0: ch = "0";
              1: ch = "a";
              2: ch = "b";
              3: ch = "f";
              4: ch = "n";
              5: ch = "r";
              6: ch = "t";
              7: ch = "v";
              8: ch = CH_BS;
              9: ch = CH_DQ;
              10: ch = CH_SQ;
              11: ch = CH_BQ;
              12: ch = " ";
              13: ch = CH_NL;
              default: ch = 8'($urandom_range(0, 255));
            endcase
          end else begin
            ch = 8'($urandom_range(32, 126));
            if (ch == q || ch == CH_BS) ch = "z";
          end
          src_add(ch);
        end
        if ($urandom_range(0, 9) != 0) src_add(q);
      end
      9: begin
        src_add("%");
        repeat ($urandom_range(0, 4)) src_add(rand_alpha());
        src_add("%");
      end
      10, 11, 12, 13: add_text(op_text[$urandom_range(0, op_text.size() - 1)]);
      14: begin
        case ($urandom_range(0, 2))
          0: src_add(" ");
          1: src_add(CH_TAB);
          default: src_add(CH_FF);
        endcase
      end
      15: begin
        src_add("#");
        repeat ($urandom_range(0, 8)) src_add(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 9) != 0) src_add(CH_NL);
      end
      16: src_add(8'($urandom_range(0, 255)));
      default: src_add(CH_NL);
    endcase
    if ($urandom_range(0, 2) != 0) src_add(" ");
  endfunction

  task automatic test_numbers_and_dots();
    gap_max = 3;
    add_text("1.2.3 4e+5L 6E7 8e- 9e+x .5 .a_ . 12L3 x.y_");
    send_source(1);
  endtask

  task automatic test_strings_and_comments();
    add_text("'a\"b\\n' \"\\q\" ");
    src_add(CH_BQ);
    src_add("x");
    src_add(CH_BS);
    src_add(CH_BQ);
    src_add(CH_BQ);
    add_text(" %in% #c\n_,;");
    src_add(CH_TAB);
    src_add(CH_FF);
    src_add(CH_CR);
    src_add(8'h00);
    src_add(8'h80);
    src_add(8'hFF);
    send_source(1);
  endtask

  task automatic test_operators();
    gap_max = 0;
    add_text("<<- <<1 <= <- -> ->> := -= :: ::: >= != == && || [[ ** + / ^ ~ $ @ {}()]");
    send_source(1);
  endtask

  task automatic test_unterminated();
    string cut[$];
    gap_max = 2;
    cut = '{"'ab", "%in", "1e", "1e-", "<<", "\"\\", "-", ">", "->", "x", ".", "1", "#c",
            "a+", ":", "::", "[", "*", "&", "|", "!", "="};
    foreach (cut[i]) begin
      add_text(cut[i]);
      send_source(1);
    end
  endtask

  task automatic test_random_sources();
    int first;
    bit paused;
    first = sent_chars;
    paused = 1'b0;
    while (sent_chars - first < 230) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 11) == 0)
        repeat ($urandom_range(1, 10)) src_add(8'($urandom_range(0, 255)));
      else
        repeat ($urandom_range(1, 10)) add_random_lexeme();
      send_source($urandom_range(0, 6) != 0);
      if (!paused && sent_chars - first >= 115) begin
        paused = 1'b1;
        wait_for_tokens();
      end
    end
    src_add(" ");
    send_source(1);
  endtask

  initial begin
    lex_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_numbers_and_dots();
    test_strings_and_comments();
    test_operators();
    test_unterminated();
    test_random_sources();
    wait_for_tokens();
    repeat (32) @(posedge clk);
    if (mism_count == 0 && tok_exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
